/* rtl/utl_pkg.sv */
// Shared types, constants and tables for the Unix time to local date pipeline.
`timescale 1ns / 1ps

package utl_pkg;

    localparam int NumStages = 10;

    typedef logic [NumStages-1:0] stage_en_t;

    typedef struct packed {
        logic [3:0] hours;
        logic       negative;
    } zone_cfg_t;

    typedef struct packed {
        logic [1:0] day_mode;
        logic [4:0] hour;
        logic [5:0] minute;
    } alarm_cfg_t;

    typedef struct packed {
        logic [7:0] year_since_2000;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       alarm_match;
    } date_time_t;

    localparam logic [2:0] CfgZoneHours    = 3'd0;
    localparam logic [2:0] CfgZoneNegative = 3'd1;
    localparam logic [2:0] CfgAlarmDayMode = 3'd2;
    localparam logic [2:0] CfgAlarmHour    = 3'd3;
    localparam logic [2:0] CfgAlarmMinute  = 3'd4;

    localparam logic [1:0] DayModeAll      = 2'd0;
    localparam logic [1:0] DayModeWeekdays = 2'd1;
    localparam logic [1:0] DayModeWeekend  = 2'd2;
    localparam logic [1:0] DayModeNever    = 2'd3;

    localparam logic [3:0]  ZoneHoursReset = 4'd8;
    localparam logic [15:0] SecPerHour     = 16'd3600;
    localparam logic [32:0] SecPerDay      = 33'd86400;

    // Reciprocals for exact division by small constants.
    localparam logic [26:0] Recip675 = 27'd101806632;
    localparam logic [15:0] Recip15  = 16'd34953;
    localparam logic [17:0] Recip7   = 18'd149797;
    localparam logic [15:0] Recip365 = 16'd45965;
    localparam logic [12:0] Recip153 = 13'd6854;

    // Day counts where the era starting in March 2000 begins, and the
    // day-of-era offset for the era that starts in March 1600.
    localparam logic [16:0] Era5FirstDay = 17'd11018;
    localparam logic [17:0] Era4DoeBias  = 18'd135079;

    // The year of era four is 1600 + yoe, so minus 2000 is yoe - 400 (mod 256).
    localparam logic [7:0] Era4YearBias = 8'd112;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

/* rtl/utl_day_split.sv */
// Zone offset and split of the local seconds count into day number and second of day.
`timescale 1ns / 1ps

module utl_day_split (
    input  logic                clk,
    input  utl_pkg::stage_en_t  load_en,
    input  utl_pkg::zone_cfg_t  zone_cfg,
    input  logic [31:0]         epoch_seconds,
    output logic [16:0]         day_num,
    output logic [16:0]         sec_of_day
);
    import utl_pkg::*;

    logic [15:0] offset;
    logic [32:0] biased_next;
    logic [32:0] biased_reg;

    logic [25:0] quot_in;
    logic [52:0] quot_prod;
    logic [16:0] quot_est_reg;
    logic [25:0] quot_in_reg;
    logic [6:0]  low_bits_reg;

    logic [26:0] back_prod;
    logic [25:0] rem_wide;
    logic [10:0] rem_est;
    logic [16:0] day_num_next;
    logic [9:0]  rem_fix;
    logic [16:0] day_num_reg;
    logic [16:0] sec_of_day_reg;

    // The day count is biased by one so that every value stays non-negative.
    assign offset = 16'(zone_cfg.hours) * SecPerHour;
    assign biased_next = zone_cfg.negative ?
                         33'(epoch_seconds) + SecPerDay - 33'(offset) :
                         33'(epoch_seconds) + SecPerDay + 33'(offset);

    always_ff @(posedge clk)
    begin
        if (load_en[0])
        begin
            biased_reg <= biased_next;
        end
    end

    // A day is 128 * 675 seconds.
    assign quot_in   = biased_reg[32:7];
    assign quot_prod = 53'(quot_in) * 53'(Recip675);

    always_ff @(posedge clk)
    begin
        if (load_en[1])
        begin
            quot_est_reg <= quot_prod[52:36];
            quot_in_reg  <= quot_in;
            low_bits_reg <= biased_reg[6:0];
        end
    end

    assign back_prod = 27'(quot_est_reg) * 27'd675;
    assign rem_wide  = quot_in_reg - back_prod[25:0];
    assign rem_est   = rem_wide[10:0];

    always_comb
    begin
        if (rem_est >= 11'd675)
        begin
            day_num_next = quot_est_reg + 17'd1;
            rem_fix      = 10'(rem_est - 11'd675);
        end
        else
        begin
            day_num_next = quot_est_reg;
            rem_fix      = rem_est[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en[2])
        begin
            day_num_reg    <= day_num_next;
            sec_of_day_reg <= {rem_fix, low_bits_reg};
        end
    end

    assign day_num    = day_num_reg;
    assign sec_of_day = sec_of_day_reg;

endmodule

/* rtl/utl_date_time.sv */
// Civil date, weekday, time of day and alarm compare from the day number and second of day.
`timescale 1ns / 1ps

module utl_date_time (
    input  logic                clk,
    input  utl_pkg::stage_en_t  load_en,
    input  utl_pkg::alarm_cfg_t alarm_cfg,
    input  logic [16:0]         day_num,
    input  logic [16:0]         sec_of_day,
    output utl_pkg::date_time_t result
);
    import utl_pkg::*;

    // Stage 3: era select, weekday quotient, total minutes.
    logic        era5_s3;
    logic [17:0] doe_s3_next;
    logic [16:0] wd_num;
    logic [34:0] wd_prod;
    logic [30:0] min_prod;
    logic        era5_s3_reg;
    logic [17:0] doe_s3_reg;
    logic [16:0] wd_num_s3_reg;
    logic [14:0] wd_quot_s3_reg;
    logic [10:0] tot_min_s3_reg;
    logic [16:0] sod_s3_reg;

    // Stage 4: century terms, weekday, second, hour.
    logic [31:0] d1460_prod;
    logic [2:0]  cent_cnt;
    logic [16:0] wd_back;
    logic [16:0] min_back;
    logic [24:0] hour_prod;
    logic [6:0]  d1460_s4_reg;
    logic [2:0]  cent_s4_reg;
    logic        last_s4_reg;
    logic [17:0] doe_s4_reg;
    logic        era5_s4_reg;
    logic [2:0]  wd_s4_reg;
    logic [5:0]  ss_s4_reg;
    logic [4:0]  hh_s4_reg;
    logic [10:0] tot_min_s4_reg;

    // Stage 5: year-of-era numerator, minute.
    logic [10:0] hour_back;
    logic [17:0] yoe_num_s5_reg;
    logic [17:0] doe_s5_reg;
    logic        era5_s5_reg;
    logic [2:0]  wd_s5_reg;
    logic [5:0]  ss_s5_reg;
    logic [4:0]  hh_s5_reg;
    logic [5:0]  mm_s5_reg;

    // Stage 6: year of era.
    logic [33:0] yoe_prod;
    logic [8:0]  yoe_s6_reg;
    logic [17:0] doe_s6_reg;
    logic        era5_s6_reg;
    logic [2:0]  wd_s6_reg;
    logic [5:0]  ss_s6_reg;
    logic [4:0]  hh_s6_reg;
    logic [5:0]  mm_s6_reg;

    // Stage 7: day of year.
    logic [1:0]  cent_yoe;
    logic [17:0] year_days;
    logic [17:0] doy_wide;
    logic [8:0]  doy_s7_reg;
    logic [8:0]  yoe_s7_reg;
    logic        era5_s7_reg;
    logic [2:0]  wd_s7_reg;
    logic [5:0]  ss_s7_reg;
    logic [4:0]  hh_s7_reg;
    logic [5:0]  mm_s7_reg;

    // Stage 8: month from March.
    logic [10:0] mp_num;
    logic [23:0] mp_prod;
    logic [3:0]  mp_s8_reg;
    logic [8:0]  doy_s8_reg;
    logic [8:0]  yoe_s8_reg;
    logic        era5_s8_reg;
    logic [2:0]  wd_s8_reg;
    logic [5:0]  ss_s8_reg;
    logic [4:0]  hh_s8_reg;
    logic [5:0]  mm_s8_reg;

    // Stage 9: output register.
    logic        early_months;
    logic [8:0]  dom_wide;
    logic        day_ok;
    date_time_t  result_next;
    date_time_t  result_reg;

    assign era5_s3     = day_num >= Era5FirstDay;
    assign doe_s3_next = era5_s3 ? 18'(day_num) - 18'(Era5FirstDay) :
                                   18'(day_num) + Era4DoeBias;
    assign wd_num      = day_num + 17'd3;
    assign wd_prod     = 35'(wd_num) * 35'(Recip7);
    assign min_prod    = 31'(sec_of_day[16:2]) * 31'(Recip15);

    always_ff @(posedge clk)
    begin
        if (load_en[3])
        begin
            era5_s3_reg    <= era5_s3;
            doe_s3_reg     <= doe_s3_next;
            wd_num_s3_reg  <= wd_num;
            wd_quot_s3_reg <= wd_prod[34:20];
            tot_min_s3_reg <= min_prod[29:19];
            sod_s3_reg     <= sec_of_day;
        end
    end

    assign d1460_prod = 32'(doe_s3_reg[17:2]) * 32'(Recip365);
    assign cent_cnt   = 3'(doe_s3_reg >= 18'd36524) + 3'(doe_s3_reg >= 18'd73048) +
                        3'(doe_s3_reg >= 18'd109572) + 3'(doe_s3_reg >= 18'd146096);
    assign wd_back    = 17'(wd_quot_s3_reg) * 17'd7;
    assign min_back   = 17'(tot_min_s3_reg) * 17'd60;
    assign hour_prod  = 25'(tot_min_s3_reg[10:2]) * 25'(Recip15);

    always_ff @(posedge clk)
    begin
        if (load_en[4])
        begin
            d1460_s4_reg   <= d1460_prod[30:24];
            cent_s4_reg    <= cent_cnt;
            last_s4_reg    <= doe_s3_reg == 18'd146096;
            doe_s4_reg     <= doe_s3_reg;
            era5_s4_reg    <= era5_s3_reg;
            wd_s4_reg      <= 3'(wd_num_s3_reg - wd_back);
            ss_s4_reg      <= 6'(sod_s3_reg - min_back);
            hh_s4_reg      <= hour_prod[23:19];
            tot_min_s4_reg <= tot_min_s3_reg;
        end
    end

    assign hour_back = 11'(hh_s4_reg) * 11'd60;

    always_ff @(posedge clk)
    begin
        if (load_en[5])
        begin
            yoe_num_s5_reg <= doe_s4_reg - 18'(d1460_s4_reg) + 18'(cent_s4_reg) -
                              18'(last_s4_reg);
            doe_s5_reg     <= doe_s4_reg;
            era5_s5_reg    <= era5_s4_reg;
            wd_s5_reg      <= wd_s4_reg;
            ss_s5_reg      <= ss_s4_reg;
            hh_s5_reg      <= hh_s4_reg;
            mm_s5_reg      <= 6'(tot_min_s4_reg - hour_back);
        end
    end

    assign yoe_prod = 34'(yoe_num_s5_reg) * 34'(Recip365);

    always_ff @(posedge clk)
    begin
        if (load_en[6])
        begin
            yoe_s6_reg  <= yoe_prod[32:24];
            doe_s6_reg  <= doe_s5_reg;
            era5_s6_reg <= era5_s5_reg;
            wd_s6_reg   <= wd_s5_reg;
            ss_s6_reg   <= ss_s5_reg;
            hh_s6_reg   <= hh_s5_reg;
            mm_s6_reg   <= mm_s5_reg;
        end
    end

    assign cent_yoe  = 2'(yoe_s6_reg >= 9'd100) + 2'(yoe_s6_reg >= 9'd200) +
                       2'(yoe_s6_reg >= 9'd300);
    assign year_days = 18'(yoe_s6_reg) * 18'd365 + 18'(yoe_s6_reg[8:2]) - 18'(cent_yoe);
    assign doy_wide  = doe_s6_reg - year_days;

    always_ff @(posedge clk)
    begin
        if (load_en[7])
        begin
            doy_s7_reg  <= doy_wide[8:0];
            yoe_s7_reg  <= yoe_s6_reg;
            era5_s7_reg <= era5_s6_reg;
            wd_s7_reg   <= wd_s6_reg;
            ss_s7_reg   <= ss_s6_reg;
            hh_s7_reg   <= hh_s6_reg;
            mm_s7_reg   <= mm_s6_reg;
        end
    end

    assign mp_num  = 11'(doy_s7_reg) * 11'd5 + 11'd2;
    assign mp_prod = 24'(mp_num) * 24'(Recip153);

    always_ff @(posedge clk)
    begin
        if (load_en[8])
        begin
            mp_s8_reg   <= mp_prod[23:20];
            doy_s8_reg  <= doy_s7_reg;
            yoe_s8_reg  <= yoe_s7_reg;
            era5_s8_reg <= era5_s7_reg;
            wd_s8_reg   <= wd_s7_reg;
            ss_s8_reg   <= ss_s7_reg;
            hh_s8_reg   <= hh_s7_reg;
            mm_s8_reg   <= mm_s7_reg;
        end
    end

    assign early_months = mp_s8_reg >= 4'd10;
    assign dom_wide     = doy_s8_reg - month_start(mp_s8_reg) + 9'd1;

    always_comb
    begin
        case (alarm_cfg.day_mode)
            DayModeAll:      day_ok = 1'b1;
            DayModeWeekdays: day_ok = (wd_s8_reg >= 3'd1) && (wd_s8_reg <= 3'd5);
            DayModeWeekend:  day_ok = (wd_s8_reg == 3'd0) || (wd_s8_reg == 3'd6);
            DayModeNever:    day_ok = 1'b0;
            default:         day_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        result_next.year_since_2000 = yoe_s8_reg[7:0] +
                                      (era5_s8_reg ? 8'd0 : Era4YearBias) +
                                      8'(early_months);
        result_next.month           = early_months ? mp_s8_reg - 4'd9 : mp_s8_reg + 4'd3;
        result_next.day_of_month    = dom_wide[4:0];
        result_next.weekday         = wd_s8_reg;
        result_next.hour            = hh_s8_reg;
        result_next.minute          = mm_s8_reg;
        result_next.second          = ss_s8_reg;
        result_next.alarm_match     = day_ok && (alarm_cfg.hour == hh_s8_reg) &&
                                      (alarm_cfg.minute == mm_s8_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load_en[9])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/unix_time_to_local_date_alarm_unit.sv */
// Unix seconds to local Gregorian date and time with a daily alarm compare.
// Each accepted input transaction passes through every pipeline stage in order to its output transaction.
// Throughput: one transaction per cycle while out_stall is low; a full stage holds when the next cannot move on.
// Reset clears all stage valid bits and loads the config registers with their reset values.
`timescale 1ns / 1ps

module unix_time_to_local_date_alarm_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  year_since_2000,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic        alarm_match,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import utl_pkg::*;

    zone_cfg_t  zone_cfg_reg;
    alarm_cfg_t alarm_cfg_reg;

    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages:0]   stage_ready;
    stage_en_t            load_en;

    logic [16:0] day_num;
    logic [16:0] sec_of_day;
    date_time_t  result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_cfg_reg.hours     <= ZoneHoursReset;
            zone_cfg_reg.negative  <= 1'b0;
            alarm_cfg_reg.day_mode <= DayModeAll;
            alarm_cfg_reg.hour     <= 5'd0;
            alarm_cfg_reg.minute   <= 6'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CfgZoneHours:    zone_cfg_reg.hours     <= cfg_data[3:0];
                CfgZoneNegative: zone_cfg_reg.negative  <= cfg_data[0];
                CfgAlarmDayMode: alarm_cfg_reg.day_mode <= cfg_data[1:0];
                CfgAlarmHour:    alarm_cfg_reg.hour     <= cfg_data[4:0];
                CfgAlarmMinute:  alarm_cfg_reg.minute   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        stage_ready[NumStages] = !out_stall;
        for (int k = NumStages - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign load_en    = stage_ready[NumStages-1:0];
    assign valid_next = {valid_reg[NumStages-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NumStages; k++)
            begin
                if (load_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign in_stall  = !stage_ready[0];
    assign out_valid = valid_reg[NumStages-1];

    utl_day_split u_day_split (
        .clk           (clk),
        .load_en       (load_en),
        .zone_cfg      (zone_cfg_reg),
        .epoch_seconds (epoch_seconds),
        .day_num       (day_num),
        .sec_of_day    (sec_of_day)
    );

    utl_date_time u_date_time (
        .clk        (clk),
        .load_en    (load_en),
        .alarm_cfg  (alarm_cfg_reg),
        .day_num    (day_num),
        .sec_of_day (sec_of_day),
        .result     (result)
    );

    assign year_since_2000 = result.year_since_2000;
    assign month           = result.month;
    assign day_of_month    = result.day_of_month;
    assign weekday         = result.weekday;
    assign hour            = result.hour;
    assign minute          = result.minute;
    assign second          = result.second;
    assign alarm_match     = result.alarm_match;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the Unix time to local date and alarm pipeline.
`timescale 1ns / 1ps

module tb_top;
    import utl_pkg::*;

    localparam int IdleLimit = 2000;
    localparam int LongHold = 120;
    localparam logic [2:0] CfgUnusedLow = 3'd5;
    localparam logic [2:0] CfgUnusedHigh = 3'd7;

    typedef struct {
        logic [31:0] stamp;
        date_time_t  date;
    } pending_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] epoch_seconds;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  year_since_2000;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        alarm_match;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [5:0]  cfg_data;

    logic [3:0] zone_hours_q;
    logic       zone_negative_q;
    logic [1:0] day_mode_q;
    logic [4:0] alarm_hour_q;
    logic [5:0] alarm_minute_q;

    pending_t pending_dates[$];
    pending_t oldest;

    int send_idle_pct;
    int stall_pct;
    logic long_hold;
    int hold_count;
    int quiet_cycles;
    int errors;
    int stamps_sent;
    int results_checked;
    int alarm_hits;
    int reg_writes;

    unix_time_to_local_date_alarm_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .epoch_seconds(epoch_seconds),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .year_since_2000(year_since_2000),
        .month(month),
        .day_of_month(day_of_month),
        .weekday(weekday),
        .hour(hour),
        .minute(minute),
        .second(second),
        .alarm_match(alarm_match),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint floor_div(input longint num, input longint den);
        longint quo;
        quo = num / den;
        if ((num % den) != 0 && num < 0)
            quo = quo - 1;
        return quo;
    endfunction

    function automatic date_time_t local_date_of(input logic [31:0] stamp);
        longint secs, offset, days, sod, z, era, doe, yoe, doy, mp;
        longint yr, mon, dom, wd, hh, mm, ss;
        logic day_ok;
        date_time_t r;
        secs = {32'd0, stamp};
        offset = longint'(zone_hours_q) * 3600;
        secs = zone_negative_q ? secs - offset : secs + offset;
        days = floor_div(secs, 86400);
        sod = secs - days * 86400;
        hh = sod / 3600;
        mm = (sod / 60) % 60;
        ss = sod % 60;
        wd = (days + 4) - floor_div(days + 4, 7) * 7;
        z = days + 719468;
        era = floor_div(z, 146097);
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        dom = doy - (153 * mp + 2) / 5 + 1;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        case (day_mode_q)
            DayModeAll:      day_ok = 1'b1;
            DayModeWeekdays: day_ok = (wd >= 1 && wd <= 5);
            DayModeWeekend:  day_ok = (wd == 0 || wd == 6);
            default:         day_ok = 1'b0;
        endcase
        r.year_since_2000 = 8'(yr - 2000);
        r.month = 4'(mon);
        r.day_of_month = 5'(dom);
        r.weekday = 3'(wd);
        r.hour = 5'(hh);
        r.minute = 6'(mm);
        r.second = 6'(ss);
        r.alarm_match = day_ok && (longint'(alarm_hour_q) == hh)
                        && (longint'(alarm_minute_q) == mm);
        return r;
    endfunction

    function automatic logic [31:0] pick_stamp();
        longint offset, local_secs;
        int jitter;
        int sel;
        offset = longint'(zone_hours_q) * 3600;
        if (zone_negative_q)
            offset = -offset;
        sel = $urandom_range(9);
        jitter = $urandom_range(7200);
        jitter = jitter - 3600;
        case (sel)
            0, 1, 2, 3:
                return $urandom();
            4, 5:
            begin
                local_secs = longint'($urandom_range(49709)) * 86400
                             + longint'(alarm_hour_q) * 3600
                             + longint'(alarm_minute_q) * 60
                             + longint'($urandom_range(59));
                return 32'(local_secs - offset);
            end
            6:
                return $urandom_range(200000);
            7:
                return 32'hFFFF_FFFF - $urandom_range(200000);
            default:
            begin
                local_secs = longint'($urandom_range(49710)) * 86400 + jitter;
                return 32'(local_secs - offset);
            end
        endcase
    endfunction

    task automatic field_check(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: stamp %0d %s expected %0d actual %0d",
                     $time, oldest.stamp, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Receiver: random stalls, or a long hold when requested.
    always @(negedge clk)
    begin
        if (long_hold && hold_count < LongHold)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (!long_hold)
                hold_count <= 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: output transaction with nothing pending", $time);
                errors++;
            end
            else
            begin
                oldest = pending_dates.pop_front();
                field_check("year_since_2000", int'($signed(oldest.date.year_since_2000)),
                            int'($signed(year_since_2000)));
                field_check("month", int'(oldest.date.month), int'(month));
                field_check("day_of_month", int'(oldest.date.day_of_month),
                            int'(day_of_month));
                field_check("weekday", int'(oldest.date.weekday), int'(weekday));
                field_check("hour", int'(oldest.date.hour), int'(hour));
                field_check("minute", int'(oldest.date.minute), int'(minute));
                field_check("second", int'(oldest.date.second), int'(second));
                field_check("alarm_match", int'(oldest.date.alarm_match), int'(alarm_match));
                results_checked++;
                if (oldest.date.alarm_match)
                    alarm_hits++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IdleLimit)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
            $display("tb_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic offer_stamp(input logic [31:0] stamp);
        pending_t entry;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        epoch_seconds <= stamp;
        entry.stamp = stamp;
        entry.date = local_date_of(stamp);
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_dates.push_back(entry);
        stamps_sent++;
        @(negedge clk);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge clk);
        repeat (NumStages + 2) @(negedge clk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [5:0] value);
        quiesce();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CfgZoneHours:    zone_hours_q = value[3:0];
            CfgZoneNegative: zone_negative_q = value[0];
            CfgAlarmDayMode: day_mode_q = value[1:0];
            CfgAlarmHour:    alarm_hour_q = value[4:0];
            CfgAlarmMinute:  alarm_minute_q = value;
            default:         ;
        endcase
        reg_writes++;
    endtask

    task automatic randomize_settings();
        program_reg(CfgZoneHours, 6'($urandom_range(15)));
        program_reg(CfgZoneNegative, 6'($urandom_range(1)));
        program_reg(CfgAlarmDayMode, 6'($urandom_range(3)));
        program_reg(CfgAlarmHour,
                    6'(($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(23)));
        program_reg(CfgAlarmMinute,
                    6'(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(59)));
        if ($urandom_range(3) == 0)
            program_reg(3'($urandom_range(CfgUnusedHigh, CfgUnusedLow)), 6'($urandom()));
    endtask

    task automatic test_default_zone();
        offer_stamp(32'd0);
        offer_stamp(32'd1);
        offer_stamp(32'd57600);
        offer_stamp(32'hFFFF_FFFF);
        offer_stamp(32'h7FFF_FFFF);
        offer_stamp(32'h8000_0000);
        offer_stamp(32'hAAAA_AAAA);
        offer_stamp(32'h5555_5555);
    endtask

    task automatic test_zone_extremes();
        program_reg(CfgZoneHours, 6'd15);
        program_reg(CfgZoneNegative, 6'd1);
        offer_stamp(32'd0);
        offer_stamp(32'd53999);
        offer_stamp(32'd54000);
        program_reg(CfgZoneNegative, 6'd0);
        offer_stamp(32'hFFFF_FFFF);
        offer_stamp(32'd951728400);
        offer_stamp(32'd4107488400);
        program_reg(CfgZoneHours, 6'd0);
        offer_stamp(32'd951868799);
        offer_stamp(32'd946684799);
    endtask

    task automatic test_alarm_day_modes();
        program_reg(CfgAlarmHour, 6'd23);
        program_reg(CfgAlarmMinute, 6'd59);
        program_reg(CfgAlarmDayMode, 6'(DayModeWeekdays));
        offer_stamp(32'd946857600 + 32'd86370);
        offer_stamp(32'd946684800 + 32'd86340);
        program_reg(CfgAlarmDayMode, 6'(DayModeWeekend));
        offer_stamp(32'd946684800 + 32'd86340);
        offer_stamp(32'd946771200 + 32'd86399);
        offer_stamp(32'd946857600 + 32'd86370);
        program_reg(CfgAlarmDayMode, 6'(DayModeNever));
        offer_stamp(32'd946684800 + 32'd86340);
        program_reg(CfgAlarmDayMode, 6'(DayModeAll));
        program_reg(CfgAlarmHour, 6'd31);
        program_reg(CfgAlarmMinute, 6'd63);
        offer_stamp(32'd946857600 + 32'd86370);
        program_reg(CfgAlarmHour, 6'd23);
        program_reg(CfgAlarmMinute, 6'd59);
        program_reg(CfgUnusedLow, 6'h3F);
        program_reg(CfgUnusedHigh, 6'h3F);
        offer_stamp(32'd946857600 + 32'd86370);
    endtask

    task automatic test_random_stamps();
        int idle_mix[4];
        int stall_mix[4];
        idle_mix = '{0, 45, 0, 7};
        stall_mix = '{0, 0, 45, 7};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_mix[p];
            stall_pct <= stall_mix[p];
            for (int c = 0; c < 6; c++)
            begin
                randomize_settings();
                repeat (55) offer_stamp(pick_stamp());
            end
        end
    endtask

    task automatic test_backpressure();
        quiesce();
        send_idle_pct = 0;
        stall_pct <= 0;
        long_hold <= 1'b1;
        repeat (40) offer_stamp(pick_stamp());
        quiesce();
        long_hold <= 1'b0;
        stall_pct <= 45;
        repeat (12) offer_stamp(pick_stamp());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        epoch_seconds = 32'd0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CfgZoneHours;
        cfg_data = 6'd0;
        long_hold = 1'b0;
        hold_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        stamps_sent = 0;
        results_checked = 0;
        alarm_hits = 0;
        reg_writes = 0;
        zone_hours_q = ZoneHoursReset;
        zone_negative_q = 1'b0;
        day_mode_q = DayModeAll;
        alarm_hour_q = 5'd0;
        alarm_minute_q = 6'd0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_zone();
        test_zone_extremes();
        test_alarm_day_modes();
        test_random_stamps();
        test_backpressure();
        quiesce();

        $display("Sent %0d stamps, checked %0d dates (%0d alarms), %0d register writes.",
                 stamps_sent, results_checked, alarm_hits, reg_writes);
        $display("Traffic ran with no gaps, sender gaps, receiver stalls, both, and a long hold.");
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
